// ----- src/scc_pkg.sv -----
// Shared types and constants for the system control coprocessor.
package scc_pkg;

   // Transfer kinds carried in the command field of a request.
   typedef enum logic [1:0] {
      CMD_MCR   = 2'd0,
      CMD_MRC   = 2'd1,
      CMD_OTHER = 2'd2
   } scc_cmd_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BIG_ENDIAN = 2'd0;
   localparam logic [1:0] CSR_ID_VALUE   = 2'd1;
   localparam logic [1:0] CSR_CACHE_TYPE = 2'd2;

   localparam logic [31:0] ID_RESET         = 32'h4156_0610;
   localparam logic [31:0] CACHE_TYPE_RESET = 32'h0000_0000;
   localparam logic [31:0] CTL_RESET        = 32'h0000_0070;

   localparam int ACCESS_W = 14;

   typedef struct packed {
      logic [1:0]  command;
      logic        privileged;
      logic [3:0]  crn;
      logic [3:0]  crm;
      logic [2:0]  op2;
      logic        dest_is_pc;
      logic [31:0] write_value;
   } scc_req_type;

   typedef struct packed {
      logic        undefined_trap;
      logic        read_valid;
      logic [31:0] read_value;
      logic        flags_only;
      logic        high_vectors;
      logic        translation_flush;
   } scc_rsp_type;

   typedef struct packed {
      logic [31:0]         control;
      logic [31:0]         aux_control;
      logic [31:0]         table_base;
      logic [31:0]         domain;
      logic [ACCESS_W-1:0] access;
   } scc_state_type;

   typedef struct packed {
      logic        big_endian;
      logic [31:0] id_value;
      logic [31:0] cache_type_value;
   } scc_cfg_type;

endpackage

// ----- src/scc_decode.sv -----
// Request decode: works out the result and the next register state for one transfer.
module scc_decode (
   input  scc_pkg::scc_req_type   req,
   input  scc_pkg::scc_state_type state_cur,
   input  scc_pkg::scc_cfg_type   cfg,
   output scc_pkg::scc_state_type state_nxt,
   output scc_pkg::scc_rsp_type   rsp
);
   import scc_pkg::*;

   localparam logic [3:0] CRN_ID      = 4'd0;
   localparam logic [3:0] CRN_CONTROL = 4'd1;
   localparam logic [3:0] CRN_BASE    = 4'd2;
   localparam logic [3:0] CRN_DOMAIN  = 4'd3;
   localparam logic [3:0] CRN_RSVD4   = 4'd4;
   localparam logic [3:0] CRN_RSVD5   = 4'd5;
   localparam logic [3:0] CRN_RSVD6   = 4'd6;
   localparam logic [3:0] CRN_CACHE   = 4'd7;
   localparam logic [3:0] CRN_ACCESS  = 4'd15;

   localparam logic [2:0] OP2_MAIN = 3'd0;
   localparam logic [2:0] OP2_ALT  = 3'd1;

   localparam logic [3:0] CRM_ACCESS = 4'd1;

   localparam logic [31:0] BASE_MASK = 32'hffff_c000;
   localparam logic [31:0] CTL_CW    = 32'h0000_000c;
   localparam logic [31:0] CTL_PDL   = 32'h0000_0070;
   localparam int          CTL_B_BIT = 7;
   localparam int          CTL_V_BIT = 13;

   // Supported cache maintenance operations, by crm and op2.
   function automatic logic cache_op_ok(input logic [3:0] crm, input logic [2:0] op2);
      logic ok;
      case (crm)
         4'd7:    ok = (op2 == 3'd0);
         4'd2:    ok = (op2 == 3'd5);
         4'd5:    ok = (op2 != 3'd3) && (op2 != 3'd5);
         4'd6:    ok = (op2 <= 3'd2);
         4'd10:   ok = (op2 == 3'd1) || (op2 == 3'd2) || (op2 == 3'd4);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   logic        wr_trap;
   logic        rd_trap;
   logic [31:0] rd_value;
   logic [31:0] ctl_value;

   always_comb begin
      ctl_value = (req.write_value & ~CTL_CW) | CTL_PDL;
      ctl_value[CTL_B_BIT] = cfg.big_endian;
   end

   // Write side: register updates and trap decision for an MCR.
   always_comb begin
      state_nxt = state_cur;
      wr_trap   = 1'b0;
      case (req.crn)
         CRN_CONTROL: begin
            if (req.op2 == OP2_MAIN) begin
               state_nxt.control = ctl_value;
            end else if (req.op2 == OP2_ALT) begin
               state_nxt.aux_control = req.write_value;
            end else begin
               wr_trap = 1'b1;
            end
         end
         CRN_BASE:   state_nxt.table_base = req.write_value & BASE_MASK;
         CRN_DOMAIN: state_nxt.domain = req.write_value;
         CRN_RSVD4, CRN_RSVD5, CRN_RSVD6: wr_trap = 1'b0;
         CRN_CACHE:  wr_trap = !cache_op_ok(req.crm, req.op2);
         CRN_ACCESS: begin
            if (req.crm == CRM_ACCESS) begin
               state_nxt.access = req.write_value[ACCESS_W-1:0];
            end else begin
               wr_trap = 1'b1;
            end
         end
         default: wr_trap = 1'b1;
      endcase
      // Only a privileged MCR may change anything.
      if (!(req.privileged && (req.command == CMD_MCR))) begin
         state_nxt = state_cur;
      end
   end

   // Read side: selected word and trap decision for an MRC.
   always_comb begin
      rd_value = '0;
      rd_trap  = 1'b0;
      case (req.crn)
         CRN_ID: begin
            if (req.op2 == OP2_MAIN) begin
               rd_value = cfg.id_value;
            end else if (req.op2 == OP2_ALT) begin
               rd_value = cfg.cache_type_value;
            end else begin
               rd_trap = 1'b1;
            end
         end
         CRN_CONTROL: begin
            if (req.op2 == OP2_MAIN) begin
               rd_value = state_cur.control;
            end else if (req.op2 == OP2_ALT) begin
               rd_value = state_cur.aux_control;
            end else begin
               rd_trap = 1'b1;
            end
         end
         CRN_BASE:   rd_value = state_cur.table_base;
         CRN_DOMAIN: rd_value = state_cur.domain;
         CRN_RSVD4, CRN_RSVD5, CRN_RSVD6, CRN_CACHE: rd_value = '0;
         CRN_ACCESS: rd_value = {{(32 - ACCESS_W){1'b0}}, state_cur.access};
         default:    rd_trap = 1'b1;
      endcase
   end

   always_comb begin
      rsp = '0;
      if (!req.privileged) begin
         rsp.undefined_trap = 1'b1;
      end else begin
         case (req.command)
            CMD_MCR: begin
               rsp.translation_flush = 1'b1;
               rsp.undefined_trap    = wr_trap;
            end
            CMD_MRC: begin
               rsp.undefined_trap = rd_trap;
               rsp.read_valid     = !rd_trap;
               rsp.read_value     = rd_trap ? 32'h0 : rd_value;
               rsp.flags_only     = !rd_trap && req.dest_is_pc;
            end
            default: rsp.undefined_trap = 1'b1;
         endcase
      end
      rsp.high_vectors = state_nxt.control[CTL_V_BIT];
   end

endmodule

// ----- src/system_control_coprocessor.sv -----
// Top level of the system control coprocessor: request and result registers and register file.
//
// Takes one coprocessor transfer per request (MCR write, MRC read or another operation) and
// returns exactly one result per request. A request is captured in an input register, decoded
// and applied to the coprocessor registers once the result register is free, and the outcome
// lands in the result register and is presented there until accepted. One request can be taken
// every cycle; the rate is set by the single decode stage between the two registers, and
// throughput drops only while the result side stalls. Configuration writes (endianness,
// identity and cache type words) are always ready and should be made while no request is in
// flight.
module system_control_coprocessor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_privileged,
   input  logic [3:0]  req_crn,
   input  logic [3:0]  req_crm,
   input  logic [2:0]  req_op2,
   input  logic        req_dest_is_pc,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_undefined_trap,
   output logic        rsp_read_valid,
   output logic [31:0] rsp_read_value,
   output logic        rsp_flags_only,
   output logic        rsp_high_vectors,
   output logic        rsp_translation_flush,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import scc_pkg::*;

   logic          req_valid_ff, req_valid_in;
   scc_req_type   req_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   scc_rsp_type   rsp_ff;
   scc_state_type state_ff, state_in;
   scc_cfg_type   cfg_ff, cfg_in;
   scc_rsp_type   rsp_in;
   logic          rsp_free;
   logic          advance;
   logic          req_take;

   // The result register is free when empty or being emptied this cycle.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_valid_in = req_take || (req_valid_ff && !rsp_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   scc_decode u_decode (
      .req       (req_ff),
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BIG_ENDIAN: cfg_in.big_endian       = csr_wdata[0];
            CSR_ID_VALUE:   cfg_in.id_value         = csr_wdata;
            CSR_CACHE_TYPE: cfg_in.cache_type_value = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{control: CTL_RESET, aux_control: '0, table_base: '0,
                           domain: '0, access: '0};
         cfg_ff       <= '{big_endian: 1'b0, id_value: ID_RESET,
                           cache_type_value: CACHE_TYPE_RESET};
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= '{command: req_command, privileged: req_privileged, crn: req_crn,
                     crm: req_crm, op2: req_op2, dest_is_pc: req_dest_is_pc,
                     write_value: req_write_value};
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_undefined_trap    = rsp_ff.undefined_trap;
   assign rsp_read_valid        = rsp_ff.read_valid;
   assign rsp_read_value        = rsp_ff.read_value;
   assign rsp_flags_only        = rsp_ff.flags_only;
   assign rsp_high_vectors      = rsp_ff.high_vectors;
   assign rsp_translation_flush = rsp_ff.translation_flush;

`ifndef ASSERT_OFF
   // The control word always keeps P, D and L set and C and W clear.
   a_control_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff.control[6:4] == 3'b111) && (state_ff.control[3:2] == 2'b00))
      else $error("control word lost its forced bits");

   // A completed read never traps and never comes with a flush.
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_valid) |->
         (!rsp_ff.undefined_trap && !rsp_ff.translation_flush))
      else $error("completed read flagged as trap or flush");

   // Flag-only transfers are a kind of completed read.
   a_flags_need_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.flags_only) |-> rsp_ff.read_valid)
      else $error("flags_only without a completed read");

   // No read data leaks out of a request that did not complete a read.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.read_valid) |-> (rsp_ff.read_value == 32'h0))
      else $error("read value not zero without a completed read");
`endif

endmodule
